[src/tlb_with_clock_replacement_top_macros.svh]
// ----------------------------------------------------------------------------
// TLB assertion macros
// Shared property forms for the checkers of the translation buffer.
// ----------------------------------------------------------------------------
`ifndef TLB_WITH_CLOCK_REPLACEMENT_TOP_MACROS_SVH
`define TLB_WITH_CLOCK_REPLACEMENT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLBCR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLBCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tlbcr_pkg.sv]
// ----------------------------------------------------------------------------
// TLB package
// Field widths, command codes and the result record of the translation buffer.
// ----------------------------------------------------------------------------
package tlbcr_pkg;

   localparam int PAGE_W = 21;
   localparam int CMD_W  = 3;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INV_PAGE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INV_ALL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_REF = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WRITEBACK = 3'd5;

   typedef struct packed {
      logic              hit;
      logic [PAGE_W-1:0] frame_out;
      logic              wb_valid;
      logic [PAGE_W-1:0] wb_frame;
      logic              wb_ref;
      logic              wb_mod;
      logic              last;
   } rsp_type;

endpackage

[src/tlb_with_clock_replacement_top.sv]
// ----------------------------------------------------------------------------
// Translation lookaside buffer with clock replacement
// Fully associative page-to-frame map with referenced and modified bits.
// ----------------------------------------------------------------------------
// A request on req_* carries a command (lookup, insert, invalidate page,
// invalidate all, clear referenced bits, write back) and is taken when
// req_valid is high and req_stall is low. Results leave on rsp_* under
// rsp_valid and rsp_stall; rsp_last marks the final result of a request.
// The block takes one request at a time and holds req_stall high while it
// works. A single compare unit walks the entries: each valid entry is read
// from the page/frame RAM and then checked, and an invalid entry is skipped
// without a read.
// csr_write_data sets the number of active entries when csr_write_en is high.
// Reset clears all valid, referenced and modified bits, the clock hand and
// sets the active count to sixteen, saturated to the built depth.
// A stalled result holds in the output register; a new request is taken
// while it waits, and the walk pauses only when it has another result ready.
module tlb_with_clock_replacement_top #(
   parameter int ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [tlbcr_pkg::CFG_W-1:0]  csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tlbcr_pkg::CMD_W-1:0]  req_cmd,
   input  logic [tlbcr_pkg::PAGE_W-1:0] req_vpage,
   input  logic                         req_is_store,
   input  logic [tlbcr_pkg::PAGE_W-1:0] req_pframe_in,
   input  logic                         req_rbit_in,
   input  logic                         req_mbit_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic [tlbcr_pkg::PAGE_W-1:0] rsp_frame_out,
   output logic                         rsp_wb_valid,
   output logic [tlbcr_pkg::PAGE_W-1:0] rsp_wb_frame,
   output logic                         rsp_wb_ref,
   output logic                         rsp_wb_mod,
   output logic                         rsp_last
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int PW = tlbcr_pkg::PAGE_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CHK = 3'd2;
   localparam logic [2:0] S_DONE     = 3'd3;
   localparam logic [2:0] S_SEARCH   = 3'd4;
   localparam logic [2:0] S_EVICT_RD = 3'd5;
   localparam logic [2:0] S_EVICT    = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [tlbcr_pkg::CFG_W-1:0]  cfg_ff, cfg_in;
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic [ENTRIES-1:0]           ref_ff, ref_in;
   logic [ENTRIES-1:0]           mod_ff, mod_in;
   logic [IW-1:0]                hand_ff, hand_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         any_ff, any_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tlbcr_pkg::rsp_type           rsp_ff, rsp_in;

   logic [tlbcr_pkg::CMD_W-1:0]  cmd_ff;
   logic [PW-1:0]                vpage_ff;
   logic                         store_ff;
   logic [PW-1:0]                pframe_ff;
   logic                         rbit_ff;
   logic                         mbit_ff;

   logic [CW-1:0]                n_act;
   logic [IW-1:0]                last_idx;
   logic [IW-1:0]                start_idx;
   logic [ENTRIES-1:0]           act_mask;
   logic [ENTRIES-1:0]           above_mask;
   logic                         more_valid;
   logic                         is_last_idx;
   logic                         out_free;
   logic                         accept;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [2*PW-1:0]              ram_rdata;
   logic [PW-1:0]                rd_page;
   logic [PW-1:0]                rd_frame;
   logic                         page_match;

   tlbcr_ram #(
      .WIDTH (2 * PW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data ({vpage_ff, pframe_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rd_page    = ram_rdata[2*PW-1:PW];
   assign rd_frame   = ram_rdata[PW-1:0];
   assign page_match = (rd_page == vpage_ff);

   always_comb begin
      if (cfg_ff == '0) begin
         n_act = CW'(1);
      end else if (32'(cfg_ff) > ENTRIES) begin
         n_act = CW'(ENTRIES);
      end else begin
         n_act = CW'(cfg_ff);
      end
   end

   assign last_idx    = IW'(n_act - CW'(1));
   assign start_idx   = (CW'(hand_ff) < n_act) ? hand_ff : '0;
   assign is_last_idx = (idx_ff == last_idx);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign accept      = req_valid && (state_ff == S_IDLE);
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         act_mask[i]   = (CW'(i) < n_act);
         above_mask[i] = (IW'(i) > idx_ff);
      end
   end

   assign more_valid = |(valid_ff & act_mask & above_mask);

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      mod_in       = mod_ff;
      hand_in      = hand_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_write_en) begin
         cfg_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               cnt_in = '0;
               any_in = 1'b0;
               case (req_cmd)
                  tlbcr_pkg::CMD_LOOKUP,
                  tlbcr_pkg::CMD_INV_PAGE,
                  tlbcr_pkg::CMD_WRITEBACK: begin
                     state_in = S_SCAN_RD;
                  end
                  tlbcr_pkg::CMD_INSERT: begin
                     idx_in   = start_idx;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            if (valid_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_SCAN_CHK;
            end else if (is_last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         S_SCAN_CHK: begin
            case (cmd_ff)
               tlbcr_pkg::CMD_LOOKUP: begin
                  if (page_match) begin
                     if (out_free) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in           = '0;
                        rsp_in.hit       = 1'b1;
                        rsp_in.frame_out = rd_frame;
                        rsp_in.last      = 1'b1;
                        ref_in[idx_ff]   = 1'b1;
                        if (store_ff) begin
                           mod_in[idx_ff] = 1'b1;
                        end
                        state_in = S_IDLE;
                     end
                  end else if (is_last_idx) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     state_in = S_SCAN_RD;
                  end
               end
               tlbcr_pkg::CMD_WRITEBACK: begin
                  if (out_free) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in          = '0;
                     rsp_in.wb_valid = 1'b1;
                     rsp_in.wb_frame = rd_frame;
                     rsp_in.wb_ref   = ref_ff[idx_ff];
                     rsp_in.wb_mod   = mod_ff[idx_ff];
                     rsp_in.last     = !more_valid;
                     any_in          = 1'b1;
                     if (is_last_idx) begin
                        state_in = S_DONE;
                     end else begin
                        idx_in   = idx_ff + IW'(1);
                        state_in = S_SCAN_RD;
                     end
                  end
               end
               default: begin
                  if (page_match) begin
                     valid_in[idx_ff] = 1'b0;
                  end
                  if (is_last_idx) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     state_in = S_SCAN_RD;
                  end
               end
            endcase
         end

         S_DONE: begin
            if ((cmd_ff == tlbcr_pkg::CMD_WRITEBACK) && any_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               if (cmd_ff == tlbcr_pkg::CMD_INV_ALL) begin
                  valid_in = valid_ff & ~act_mask;
               end
               if (cmd_ff == tlbcr_pkg::CMD_CLEAR_REF) begin
                  ref_in = ref_ff & ~act_mask;
               end
               state_in = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (!valid_ff[idx_ff] || !ref_ff[idx_ff]) begin
               state_in = S_EVICT_RD;
            end else if (cnt_ff == CW'(n_act - CW'(1))) begin
               idx_in   = start_idx;
               state_in = S_EVICT_RD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               idx_in = is_last_idx ? '0 : idx_ff + IW'(1);
            end
         end

         S_EVICT_RD: begin
            ram_rd_en = valid_ff[idx_ff];
            state_in  = S_EVICT;
         end

         S_EVICT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               if (valid_ff[idx_ff]) begin
                  rsp_in.wb_valid = 1'b1;
                  rsp_in.wb_frame = rd_frame;
                  rsp_in.wb_ref   = ref_ff[idx_ff];
                  rsp_in.wb_mod   = mod_ff[idx_ff];
               end
               ram_wr_en        = 1'b1;
               valid_in[idx_ff] = 1'b1;
               ref_in[idx_ff]   = rbit_ff;
               mod_in[idx_ff]   = mbit_ff;
               hand_in          = is_last_idx ? '0 : idx_ff + IW'(1);
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= tlbcr_pkg::CFG_RESET;
         valid_ff     <= '0;
         ref_ff       <= '0;
         mod_ff       <= '0;
         hand_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         mod_ff       <= mod_in;
         hand_ff      <= hand_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         vpage_ff  <= req_vpage;
         store_ff  <= req_is_store;
         pframe_ff <= req_pframe_in;
         rbit_ff   <= req_rbit_in;
         mbit_ff   <= req_mbit_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_frame_out = rsp_ff.frame_out;
   assign rsp_wb_valid  = rsp_ff.wb_valid;
   assign rsp_wb_frame  = rsp_ff.wb_frame;
   assign rsp_wb_ref    = rsp_ff.wb_ref;
   assign rsp_wb_mod    = rsp_ff.wb_mod;
   assign rsp_last      = rsp_ff.last;

endmodule

[src/tlbcr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbcr_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/tlbcr_checker.sv]
// ----------------------------------------------------------------------------
// TLB port checker
// Watches the ports of the translation buffer and flags illegal behavior.
// ----------------------------------------------------------------------------
`include "tlb_with_clock_replacement_top_macros.svh"

module tlbcr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_hit,
   input logic [tlbcr_pkg::PAGE_W-1:0] rsp_frame_out,
   input logic                         rsp_wb_valid,
   input logic [tlbcr_pkg::PAGE_W-1:0] rsp_wb_frame,
   input logic                         rsp_wb_ref,
   input logic                         rsp_wb_mod,
   input logic                         rsp_last
);

   `TLBCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit) && $stable(rsp_frame_out) && $stable(rsp_wb_valid)
      && $stable(rsp_wb_frame) && $stable(rsp_wb_ref) && $stable(rsp_wb_mod)
      && $stable(rsp_last), "Stalled result changed.")

   `TLBCR_ASSERT_IMPLIES(a_hit_alone, clock, reset, rsp_valid && rsp_hit,
      !rsp_wb_valid && rsp_last, "A lookup hit carried a write-back or was not last.")

   `TLBCR_ASSERT_IMPLIES(a_wb_zero, clock, reset, rsp_valid && !rsp_wb_valid,
      (rsp_wb_frame == '0) && !rsp_wb_ref && !rsp_wb_mod,
      "Write-back fields were not zero without a write-back.")

   `TLBCR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall,
      req_stall, "A second request was taken right after the first.")

endmodule

bind tlb_with_clock_replacement_top tlbcr_checker u_checker (.*);
